// ----- rtl/core/cubic_bezier_y_extrema_top_assert.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the cubic bezier y extrema block
// concurrent checks, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_Y_EXTREMA_TOP_ASSERT_SVH
`define CUBIC_BEZIER_Y_EXTREMA_TOP_ASSERT_SVH

// same-cycle implication
`define CBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/cbe_pkg.sv -----
// ----------------------------------------------------------------------------
// cbe_pkg
// types, stage map and per-stage datapath functions of the y extrema pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package cbe_pkg;

    localparam int C_FRAC     = 16;
    localparam int C_SQ_BITS  = 34;
    localparam int C_SQ_PER   = 2;
    localparam int C_SQ_ST    = (C_SQ_BITS + C_SQ_PER - 1) / C_SQ_PER;
    localparam int C_DIV_PER  = 2;
    localparam int C_DIV_ST   = (C_FRAC + C_DIV_PER - 1) / C_DIV_PER;
    localparam int C_RND      = 1 << (C_FRAC - 1);

    // stage map
    localparam int K_PREP  = 0;
    localparam int K_MUL   = K_PREP + 1;
    localparam int K_DISC  = K_MUL + 1;
    localparam int K_SQ0   = K_DISC + 1;
    localparam int K_ROOT  = K_SQ0 + C_SQ_ST;
    localparam int K_DIV0  = K_ROOT + 1;
    localparam int K_EV0   = K_DIV0 + C_DIV_ST;
    localparam int K_EV1   = K_EV0 + 1;
    localparam int K_EV2   = K_EV1 + 1;
    localparam int K_OUT   = K_EV2 + 1;
    localparam int C_N_STG = K_OUT + 1;

    typedef logic signed [35:0] t_crd;
    typedef logic signed [37:0] t_dif;
    typedef logic [C_FRAC-1:0]  t_q;
    typedef logic [C_FRAC:0]    t_u;

    localparam t_u C_ONE_U = t_u'(1) << C_FRAC;

    typedef struct packed {
        t_crd [3:0]      px;
        t_crd [3:0]      py;
        t_dif            d1;
        t_dif            d2;
        t_dif            d3;
        t_dif            d12;
        t_dif            qa;
        logic signed [69:0] prod;
        logic [67:0]     sq;
        logic            endp;
        logic [67:0]     srem;
        logic [C_SQ_BITS-1:0] sroot;
        logic            z0;
        logic            z1;
        logic            o0;
        logic            o1;
        logic [37:0]     am;
        logic [37:0]     dr0;
        logic [37:0]     dr1;
        t_q              q0;
        t_q              q1;
        t_u              u0;
        t_u              u1;
        t_crd [3:0][2:0] lv;
        logic [31:0]     lo_x;
        logic [31:0]     lo_y;
        logic [31:0]     hi_x;
        logic [31:0]     hi_y;
    } t_pipe;

    // a + round((b - a) * u / 2^frac), ties up
    function automatic t_crd f_lerp(input t_crd a, input t_crd b, input t_u u);
        logic signed [36:0] df;
        logic signed [55:0] pr;
        df = 37'(b) - 37'(a);
        pr = df * $signed({1'b0, u});
        pr = pr + C_RND;
        pr = pr >>> C_FRAC;
        return t_crd'(a + pr[35:0]);
    endfunction

    function automatic logic [31:0] f_sat(input t_crd v);
        logic [31:0] r;
        if (v > $signed(36'h07FFFFFFF)) begin
            r = 32'h7FFFFFFF;
        end else if (v < $signed(36'hF80000000)) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_pipe f_prep(
        input logic signed [31:0] sx,
        input logic signed [31:0] sy,
        input logic signed [31:0] hdx,
        input logic signed [31:0] hdy,
        input logic signed [31:0] ehdx,
        input logic signed [31:0] ehdy,
        input logic signed [31:0] ex,
        input logic signed [31:0] ey
    );
        t_pipe o;
        t_crd  y1;
        t_crd  y2;
        o = '0;
        y1 = t_crd'(sy) + t_crd'(hdy);
        y2 = t_crd'(ey) + t_crd'(ehdy);
        o.px[0] = t_crd'(sx);
        o.px[1] = t_crd'(sx) + t_crd'(hdx);
        o.px[2] = t_crd'(ex) + t_crd'(ehdx);
        o.px[3] = t_crd'(ex);
        o.py[0] = t_crd'(sy);
        o.py[1] = y1;
        o.py[2] = y2;
        o.py[3] = t_crd'(ey);
        o.d1 = t_dif'(hdy);
        o.d3 = -t_dif'(ehdy);
        o.d2 = t_dif'(y2) - t_dif'(y1);
        return o;
    endfunction

    function automatic t_pipe f_stage(input int k, input t_pipe s);
        t_pipe o;
        t_dif  t2;
        logic [33:0] m2;
        logic signed [69:0] ds;
        logic [69:0] tr;
        logic [69:0] rw;
        int st;
        int b;
        int c;
        int i;
        t_dif n0;
        t_dif n1;
        t_dif a_m;
        logic [38:0] dw;
        t_u   uc;
        t_crd [3:0] pp;
        t_crd ya;
        t_crd yb;
        t_crd xa;
        t_crd xb;
        o = s;
        if (k == K_MUL) begin
            t2 = s.d2[37] ? -s.d2 : s.d2;
            m2 = t2[33:0];
            o.prod = $signed(s.d1[31:0]) * $signed(s.d3[32:0]);
            o.sq = m2 * m2;
            o.d12 = s.d1 - s.d2;
            o.qa = s.d1 - (s.d2 <<< 1) + s.d3;
        end else if (k == K_DISC) begin
            ds = $signed({2'b00, s.sq}) - s.prod;
            o.endp = (s.qa == '0) || ds[69];
            o.srem = ds[67:0];
            o.sroot = '0;
        end else if (k >= K_SQ0 && k < K_ROOT) begin
            // two result bits per stage, rem tracks d - root^2
            for (i = 0; i < C_SQ_PER; i++) begin
                st = (k - K_SQ0) * C_SQ_PER + i;
                if (st < C_SQ_BITS) begin
                    b = C_SQ_BITS - 1 - st;
                    tr = (70'(o.sroot) << (b + 1)) + (70'(1) << (2 * b));
                    rw = 70'(o.srem);
                    if (rw >= tr) begin
                        rw = rw - tr;
                        o.srem = rw[67:0];
                        o.sroot[b] = 1'b1;
                    end
                end
            end
        end else if (k == K_ROOT) begin
            n0 = s.d12 + $signed({4'b0000, s.sroot});
            n1 = s.d12 - $signed({4'b0000, s.sroot});
            a_m = s.qa[37] ? -s.qa : s.qa;
            o.am = a_m;
            o.z0 = (n0 == '0) || (n0[37] != s.qa[37]);
            o.z1 = (n1 == '0) || (n1[37] != s.qa[37]);
            o.dr0 = n0[37] ? -n0 : n0;
            o.dr1 = n1[37] ? -n1 : n1;
            o.o0 = !o.z0 && (o.dr0 >= o.am);
            o.o1 = !o.z1 && (o.dr1 >= o.am);
            o.q0 = '0;
            o.q1 = '0;
        end else if (k >= K_DIV0 && k < K_EV0) begin
            // restoring divide, quotient below one
            for (i = 0; i < C_DIV_PER; i++) begin
                st = (k - K_DIV0) * C_DIV_PER + i;
                if (st < C_FRAC) begin
                    dw = {o.dr0, 1'b0};
                    if (dw >= {1'b0, o.am}) begin
                        dw = dw - {1'b0, o.am};
                        o.q0 = {o.q0[C_FRAC-2:0], 1'b1};
                    end else begin
                        o.q0 = {o.q0[C_FRAC-2:0], 1'b0};
                    end
                    o.dr0 = dw[37:0];
                    dw = {o.dr1, 1'b0};
                    if (dw >= {1'b0, o.am}) begin
                        dw = dw - {1'b0, o.am};
                        o.q1 = {o.q1[C_FRAC-2:0], 1'b1};
                    end else begin
                        o.q1 = {o.q1[C_FRAC-2:0], 1'b0};
                    end
                    o.dr1 = dw[37:0];
                end
            end
        end else if (k == K_EV0) begin
            o.u0 = s.z0 ? '0 : (s.o0 ? C_ONE_U : {1'b0, s.q0});
            o.u1 = s.z1 ? '0 : (s.o1 ? C_ONE_U : {1'b0, s.q1});
            // curves: x at u0, x at u1, y at u0, y at u1
            for (c = 0; c < 4; c++) begin
                pp = (c < 2) ? s.px : s.py;
                uc = ((c & 1) != 0) ? o.u1 : o.u0;
                for (i = 0; i < 3; i++) begin
                    o.lv[c][i] = f_lerp(pp[i], pp[i+1], uc);
                end
            end
        end else if (k == K_EV1) begin
            for (c = 0; c < 4; c++) begin
                uc = ((c & 1) != 0) ? s.u1 : s.u0;
                for (i = 0; i < 2; i++) begin
                    o.lv[c][i] = f_lerp(s.lv[c][i], s.lv[c][i+1], uc);
                end
            end
        end else if (k == K_EV2) begin
            for (c = 0; c < 4; c++) begin
                uc = ((c & 1) != 0) ? s.u1 : s.u0;
                o.lv[c][0] = f_lerp(s.lv[c][0], s.lv[c][1], uc);
            end
        end else if (k == K_OUT) begin
            if (s.endp) begin
                ya = s.py[0];
                yb = s.py[3];
                xa = s.px[0];
                xb = s.px[3];
            end else begin
                ya = s.lv[2][0];
                yb = s.lv[3][0];
                xa = s.lv[0][0];
                xb = s.lv[1][0];
            end
            if (ya < yb) begin
                o.lo_x = f_sat(xa);
                o.lo_y = f_sat(ya);
                o.hi_x = f_sat(xb);
                o.hi_y = f_sat(yb);
            end else begin
                o.lo_x = f_sat(xb);
                o.lo_y = f_sat(yb);
                o.hi_x = f_sat(xa);
                o.hi_y = f_sat(ya);
            end
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cbe_if.sv -----
// ----------------------------------------------------------------------------
// cbe_if
// valid/ready channels for curve segments and extrema pairs
// ----------------------------------------------------------------------------
`default_nettype none

interface cbe_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_handle_dx;
    logic signed [31:0] start_handle_dy;
    logic signed [31:0] end_handle_dx;
    logic signed [31:0] end_handle_dy;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;

    modport source (
        output valid, start_x, start_y, start_handle_dx, start_handle_dy,
               end_handle_dx, end_handle_dy, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_handle_dx, start_handle_dy,
               end_handle_dx, end_handle_dy, end_x, end_y,
        output ready
    );
endinterface

interface cbe_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] low_point_x;
    logic signed [31:0] low_point_y;
    logic signed [31:0] high_point_x;
    logic signed [31:0] high_point_y;

    modport source (
        output valid, low_point_x, low_point_y, high_point_x, high_point_y,
        input  ready
    );
    modport sink (
        input  valid, low_point_x, low_point_y, high_point_x, high_point_y,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/cubic_bezier_y_extrema_top.sv -----
// throughput: one segment per cycle while the output is not stalled; 17 square root stages (two bits each)
//   and 8 divide stages (two quotient bits each) set the depth
// each stage holds while it is full and the next stage holds, so bubbles fill during a stall
// reset: synchronous active low, clears every stage valid bit
// ----------------------------------------------------------------------------
// cubic_bezier_y_extrema_top
// pipelined y extrema of a cubic bezier segment in q16.16
// ----------------------------------------------------------------------------
`default_nettype none

`include "cubic_bezier_y_extrema_top_assert.svh"

module cubic_bezier_y_extrema_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cbe_in_if.sink        i_seg,
    cbe_out_if.source     o_ext
);

    localparam int N = cbe_pkg::C_N_STG;

    cbe_pkg::t_pipe r_st  [N];
    cbe_pkg::t_pipe n_st  [N];
    logic           r_vld [N];
    logic [N-1:0]   w_en;
    logic [N-1:0]   w_vin;
    logic [N-1:0]   w_vld;

    assign n_st[0] = cbe_pkg::f_prep(i_seg.start_x, i_seg.start_y,
        i_seg.start_handle_dx, i_seg.start_handle_dy,
        i_seg.end_handle_dx, i_seg.end_handle_dy, i_seg.end_x, i_seg.end_y);

    assign w_vin[0] = i_seg.valid;
    assign w_en[N-1] = !r_vld[N-1] || o_ext.ready;

    genvar k;
    generate
        for (k = 1; k < N; k++) begin : g_fn
            assign n_st[k] = cbe_pkg::f_stage(k, r_st[k-1]);
            assign w_vin[k] = r_vld[k-1];
        end
        for (k = 0; k < N - 1; k++) begin : g_en
            // a stage moves when empty or when its successor moves
            assign w_en[k] = !r_vld[k] || w_en[k+1];
        end
        for (k = 0; k < N; k++) begin : g_stg
            assign w_vld[k] = r_vld[k];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_en[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_st[k] <= n_st[k];
                end
            end
        end
    endgenerate

    assign i_seg.ready        = w_en[0];
    assign o_ext.valid        = r_vld[N-1];
    assign o_ext.low_point_x  = $signed(r_st[N-1].lo_x);
    assign o_ext.low_point_y  = $signed(r_st[N-1].lo_y);
    assign o_ext.high_point_x = $signed(r_st[N-1].hi_x);
    assign o_ext.high_point_y = $signed(r_st[N-1].hi_y);

    `CBE_ASSERT_IMP(a_sqrt_floor, i_clk, i_rst_n, r_vld[cbe_pkg::K_ROOT-1] && !r_st[cbe_pkg::K_ROOT-1].endp, r_st[cbe_pkg::K_ROOT-1].srem <= 68'({r_st[cbe_pkg::K_ROOT-1].sroot, 1'b0}), "square root remainder out of range")
    `CBE_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, !i_seg.ready, (&w_vld) && !o_ext.ready, "input held off with room in the pipeline")
    `CBE_ASSERT_IMP(a_u_range, i_clk, i_rst_n, r_vld[cbe_pkg::K_EV0], (r_st[cbe_pkg::K_EV0].u0 <= cbe_pkg::C_ONE_U) && (r_st[cbe_pkg::K_EV0].u1 <= cbe_pkg::C_ONE_U), "curve parameter above one")

endmodule

`default_nettype wire
